FILE: rtl/dbrm_pkg.sv
// shared types and constants for the display buffer ring manager
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package dbrm_pkg;

    // field widths of the channels
    localparam int OP_W       = 2;
    localparam int SLOT_IN_W  = 4;
    localparam int LAYERS_W   = 4;
    localparam int SEQ_W      = 32;
    localparam int PERIOD_W   = 63;
    localparam int STATUS_W   = 4;
    localparam int SLOT_OUT_W = 3;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int DIV_CNT_W  = 6;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          slot_state_t;

    // operations
    localparam op_t OP_ACQUIRE = 2'd0;
    localparam op_t OP_PRESENT = 2'd1;
    localparam op_t OP_SETTLE  = 2'd2;
    localparam op_t OP_FLIP    = 2'd3;

    // result status codes
    localparam status_t STAT_OK          = 4'd0;
    localparam status_t STAT_NONE_FREE   = 4'd1;
    localparam status_t STAT_POWERED_OFF = 4'd2;
    localparam status_t STAT_RECONFIG    = 4'd3;
    localparam status_t STAT_BAD_LAYERS  = 4'd4;
    localparam status_t STAT_NOT_OWNED   = 4'd5;
    localparam status_t STAT_BUSY        = 4'd6;
    localparam status_t STAT_HELD        = 4'd7;
    localparam status_t STAT_COMMIT_FAIL = 4'd8;
    localparam status_t STAT_STALE       = 4'd9;

    // slot states
    localparam slot_state_t ST_FREE      = 2'd0;
    localparam slot_state_t ST_ACQUIRED  = 2'd1;
    localparam slot_state_t ST_COMMITTED = 2'd2;
    localparam slot_state_t ST_SCANOUT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWERED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FENCE   = 2'd2;

endpackage

FILE: rtl/dbrm_if.sv
// valid/ready channel interfaces: request, result and configuration write
// depends on dbrm_pkg for field widths
`timescale 1ns / 1ps

interface dbrm_req_if;
    logic                                valid;
    logic                                ready;
    logic [dbrm_pkg::OP_W-1:0]           operation;
    logic [dbrm_pkg::SLOT_IN_W-1:0]      slot;
    logic [dbrm_pkg::LAYERS_W-1:0]       layer_count;
    logic                                render_complete;
    logic                                fence_exported;
    logic                                commit_ok;
    logic [dbrm_pkg::SEQ_W-1:0]          vblank_sequence;
    logic [dbrm_pkg::PERIOD_W-1:0]       event_time;

    modport source (
        output valid, operation, slot, layer_count, render_complete,
               fence_exported, commit_ok, vblank_sequence, event_time,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, layer_count, render_complete,
               fence_exported, commit_ok, vblank_sequence, event_time,
        output ready
    );
endinterface

interface dbrm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [dbrm_pkg::STATUS_W-1:0]       status;
    logic [dbrm_pkg::SLOT_OUT_W-1:0]     acquired_slot;
    logic [dbrm_pkg::SLOT_OUT_W-1:0]     shown_slot;
    logic                                presented;
    logic [dbrm_pkg::PERIOD_W-1:0]       period_ns;
    logic [dbrm_pkg::COUNT_W-1:0]        held_total;
    logic [dbrm_pkg::COUNT_W-1:0]        commit_total;

    modport source (
        output valid, status, acquired_slot, shown_slot, presented,
               period_ns, held_total, commit_total,
        input  ready
    );
    modport sink (
        input  valid, status, acquired_slot, shown_slot, presented,
               period_ns, held_total, commit_total,
        output ready
    );
endinterface

interface dbrm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dbrm_pkg::CFG_IDX_W-1:0]      index;
    logic [dbrm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/display_buffer_ring_manager_top.sv
// display buffer ring manager: slot ring, present/settle/flip control, period divider
// depends on dbrm_pkg and the channel interfaces in dbrm_if.sv
// present, settle, stale flip, a credited flip with no known period and acquire on an empty ring
// go from decode to emit; else a credited flip runs a 63-step bit-serial divide of elapsed time
// by sequence delta; acquire normalises the pointer by subtraction and scans one slot per cycle;
// a result not taken stalls the next item in its emit step. reset: slot 0 scanout, rest free
`timescale 1ns / 1ps

module display_buffer_ring_manager_top #(
    parameter int RING_SLOTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    dbrm_req_if.sink   req,
    dbrm_rsp_if.source rsp,
    dbrm_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam int N_W   = IDX_W + 1;
    localparam logic [dbrm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        dbrm_pkg::DIV_CNT_W'(dbrm_pkg::PERIOD_W - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg;

    // configuration registers
    logic                               cfg_powered_reg;
    logic [dbrm_pkg::CFG_DATA_W-1:0]    cfg_slots_reg;
    logic                               cfg_fence_reg;

    // ring state
    dbrm_pkg::slot_state_t slot_state_reg [RING_SLOTS];
    logic [IDX_W-1:0]                   next_ptr_reg;
    logic [IDX_W-1:0]                   scanout_slot_reg;
    logic                               inflight_valid_reg;
    logic [IDX_W-1:0]                   inflight_slot_reg;
    logic                               pending_valid_reg;
    logic [IDX_W-1:0]                   pending_slot_reg;
    logic                               have_prev_reg;
    logic [dbrm_pkg::PERIOD_W-1:0]      last_time_reg;
    logic [dbrm_pkg::SEQ_W-1:0]         last_seq_reg;
    logic [dbrm_pkg::COUNT_W-1:0]       held_cnt_reg;
    logic [dbrm_pkg::COUNT_W-1:0]       commit_cnt_reg;

    // latched request
    dbrm_pkg::op_t                      op_reg;
    logic [dbrm_pkg::SLOT_IN_W-1:0]     slot_reg;
    logic [dbrm_pkg::LAYERS_W-1:0]      layers_reg;
    logic                               done_reg;
    logic                               fence_reg;
    logic                               ok_reg;
    logic [dbrm_pkg::SEQ_W-1:0]         seq_reg;
    logic [dbrm_pkg::PERIOD_W-1:0]      at_reg;

    // search and divide working registers
    logic [IDX_W-1:0]                   ptr_reg;
    logic [N_W-1:0]                     cnt_reg;
    logic [dbrm_pkg::DIV_CNT_W-1:0]     div_cnt_reg;
    logic [dbrm_pkg::PERIOD_W-1:0]      dq_reg;
    logic [dbrm_pkg::SEQ_W-1:0]         rem_reg;
    logic [dbrm_pkg::SEQ_W-1:0]         dvs_reg;

    // result being built
    dbrm_pkg::status_t                  res_status_reg;
    logic [IDX_W-1:0]                   res_acq_reg;
    logic [IDX_W-1:0]                   res_shown_reg;
    logic                               res_presented_reg;

    // output register
    logic                               rsp_valid_reg;
    dbrm_pkg::status_t                  rsp_status_reg;
    logic [dbrm_pkg::SLOT_OUT_W-1:0]    rsp_acq_reg;
    logic [dbrm_pkg::SLOT_OUT_W-1:0]    rsp_shown_reg;
    logic                               rsp_presented_reg;
    logic [dbrm_pkg::PERIOD_W-1:0]      rsp_period_reg;
    logic [dbrm_pkg::COUNT_W-1:0]       rsp_held_reg;
    logic [dbrm_pkg::COUNT_W-1:0]       rsp_commit_reg;

    logic                               req_fire;
    logic                               emit_fire;
    logic [N_W-1:0]                     ring_n;
    logic [IDX_W-1:0]                   idx_next;
    logic [N_W-1:0]                     cnt_next;
    logic                               slot_in_ring;
    logic [IDX_W-1:0]                   slot_idx;
    logic [dbrm_pkg::PERIOD_W:0]        time_diff;
    logic [dbrm_pkg::SEQ_W-1:0]         seq_delta;
    logic                               period_known;
    logic [dbrm_pkg::SEQ_W:0]           div_trial;
    logic                               div_ge;

    // handshakes, both closed while in reset
    assign req.ready = rst_n && (state_reg == S_IDLE);
    assign cfg.ready = rst_n;
    assign req_fire  = req.valid && req.ready;
    assign emit_fire = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp.ready);

    // effective ring size, clipped to storage
    assign ring_n = ({1'b0, cfg_slots_reg} < 5'(RING_SLOTS)) ? N_W'(cfg_slots_reg)
                                                              : N_W'(RING_SLOTS);

    // round robin successor of the slot under test
    assign idx_next = (N_W'({1'b0, ptr_reg} + N_W'(1)) == ring_n) ? '0
                                                                  : IDX_W'(ptr_reg + 1'b1);
    assign cnt_next = N_W'(cnt_reg + N_W'(1));

    // present slot range check
    assign slot_in_ring = (5'(slot_reg) < 5'(ring_n));
    assign slot_idx     = IDX_W'(slot_reg);

    // period qualification; top bit of the difference flags time going backwards
    assign time_diff    = {1'b0, at_reg} - {1'b0, last_time_reg};
    assign seq_delta    = seq_reg - last_seq_reg;
    assign period_known = have_prev_reg && (seq_reg > last_seq_reg)
                          && !time_diff[dbrm_pkg::PERIOD_W];

    // one restoring division step
    assign div_trial = {rem_reg, dq_reg[dbrm_pkg::PERIOD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= req.operation;
            slot_reg   <= req.slot;
            layers_reg <= req.layer_count;
            done_reg   <= req.render_complete;
            fence_reg  <= req.fence_exported;
            ok_reg     <= req.commit_ok;
            seq_reg    <= req.vblank_sequence;
            at_reg     <= req.event_time;
        end
    end

    // result register load
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            rsp_status_reg    <= res_status_reg;
            rsp_acq_reg       <= dbrm_pkg::SLOT_OUT_W'(res_acq_reg);
            rsp_shown_reg     <= dbrm_pkg::SLOT_OUT_W'(res_shown_reg);
            rsp_presented_reg <= res_presented_reg;
            rsp_period_reg    <= dq_reg;
            rsp_held_reg      <= held_cnt_reg;
            rsp_commit_reg    <= commit_cnt_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_powered_reg <= 1'b1;
            cfg_slots_reg   <= 4'd3;
            cfg_fence_reg   <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                dbrm_pkg::REG_POWERED: cfg_powered_reg <= cfg.data[0];
                dbrm_pkg::REG_SLOTS:   cfg_slots_reg   <= cfg.data;
                dbrm_pkg::REG_FENCE:   cfg_fence_reg   <= cfg.data[0];
                default:               ;
            endcase
        end
    end

    // sequencer and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                slot_state_reg[i] <= dbrm_pkg::ST_FREE;
            end
            slot_state_reg[0]  <= dbrm_pkg::ST_SCANOUT;
            next_ptr_reg       <= '0;
            scanout_slot_reg   <= '0;
            inflight_valid_reg <= 1'b0;
            inflight_slot_reg  <= '0;
            pending_valid_reg  <= 1'b0;
            pending_slot_reg   <= '0;
            have_prev_reg      <= 1'b0;
            last_time_reg      <= '0;
            last_seq_reg       <= '0;
            held_cnt_reg       <= '0;
            commit_cnt_reg     <= '0;
            ptr_reg            <= '0;
            cnt_reg            <= '0;
            div_cnt_reg        <= '0;
            dq_reg             <= '0;
            rem_reg            <= '0;
            dvs_reg            <= '0;
            res_status_reg     <= dbrm_pkg::STAT_OK;
            res_acq_reg        <= '0;
            res_shown_reg      <= '0;
            res_presented_reg  <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            // output transfer taken
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                end

                // decode and apply the operation
                S_EXEC:
                begin
                    res_status_reg    <= dbrm_pkg::STAT_OK;
                    res_acq_reg       <= '0;
                    res_shown_reg     <= '0;
                    res_presented_reg <= 1'b0;
                    dq_reg            <= '0;
                    state_reg         <= S_EMIT;
                    unique case (op_reg)
                        dbrm_pkg::OP_ACQUIRE:
                        begin
                            if (ring_n == '0)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_NONE_FREE;
                            end
                            else
                            begin
                                ptr_reg   <= next_ptr_reg;
                                state_reg <= S_NORM;
                            end
                        end

                        dbrm_pkg::OP_PRESENT:
                        begin
                            if (!cfg_powered_reg)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_POWERED_OFF;
                            end
                            else if (ring_n == '0)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_RECONFIG;
                            end
                            else if (layers_reg != 4'd1)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_BAD_LAYERS;
                            end
                            else if (!slot_in_ring)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_NOT_OWNED;
                            end
                            else if (inflight_valid_reg || pending_valid_reg)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_BUSY;
                            end
                            else if ((cfg_fence_reg && fence_reg) || done_reg)
                            begin
                                if (ok_reg)
                                begin
                                    slot_state_reg[slot_idx] <= dbrm_pkg::ST_COMMITTED;
                                    inflight_valid_reg       <= 1'b1;
                                    inflight_slot_reg        <= slot_idx;
                                    commit_cnt_reg           <= commit_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    res_status_reg <= dbrm_pkg::STAT_COMMIT_FAIL;
                                end
                            end
                            else
                            begin
                                // hold the frame until rendering completes
                                pending_valid_reg <= 1'b1;
                                pending_slot_reg  <= slot_idx;
                                held_cnt_reg      <= held_cnt_reg + 1'b1;
                                res_status_reg    <= dbrm_pkg::STAT_HELD;
                            end
                        end

                        dbrm_pkg::OP_SETTLE:
                        begin
                            if (pending_valid_reg)
                            begin
                                if (done_reg)
                                begin
                                    pending_valid_reg <= 1'b0;
                                    if (ok_reg)
                                    begin
                                        slot_state_reg[pending_slot_reg] <=
                                            dbrm_pkg::ST_COMMITTED;
                                        inflight_valid_reg <= 1'b1;
                                        inflight_slot_reg  <= pending_slot_reg;
                                        commit_cnt_reg     <= commit_cnt_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        slot_state_reg[pending_slot_reg] <= dbrm_pkg::ST_FREE;
                                        res_status_reg <= dbrm_pkg::STAT_COMMIT_FAIL;
                                    end
                                end
                                else
                                begin
                                    res_status_reg <= dbrm_pkg::STAT_HELD;
                                end
                            end
                        end

                        dbrm_pkg::OP_FLIP:
                        begin
                            if (!inflight_valid_reg)
                            begin
                                res_status_reg <= dbrm_pkg::STAT_STALE;
                            end
                            else
                            begin
                                // committed slot goes to scanout, previous scanout freed
                                inflight_valid_reg <= 1'b0;
                                if (scanout_slot_reg != inflight_slot_reg)
                                begin
                                    slot_state_reg[scanout_slot_reg] <= dbrm_pkg::ST_FREE;
                                end
                                slot_state_reg[inflight_slot_reg] <= dbrm_pkg::ST_SCANOUT;
                                scanout_slot_reg  <= inflight_slot_reg;
                                res_shown_reg     <= inflight_slot_reg;
                                res_presented_reg <= 1'b1;
                                last_time_reg     <= at_reg;
                                last_seq_reg      <= seq_reg;
                                have_prev_reg     <= 1'b1;
                                if (period_known)
                                begin
                                    dq_reg      <= time_diff[dbrm_pkg::PERIOD_W-1:0];
                                    dvs_reg     <= seq_delta;
                                    rem_reg     <= '0;
                                    div_cnt_reg <= '0;
                                    state_reg   <= S_DIV;
                                end
                            end
                        end

                        default: ;
                    endcase
                end

                // bring the search start inside the ring
                S_NORM:
                begin
                    if ({1'b0, ptr_reg} >= ring_n)
                    begin
                        ptr_reg <= IDX_W'({1'b0, ptr_reg} - ring_n);
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end

                // one slot examined per cycle
                S_SCAN:
                begin
                    if (slot_state_reg[ptr_reg] == dbrm_pkg::ST_FREE)
                    begin
                        slot_state_reg[ptr_reg] <= dbrm_pkg::ST_ACQUIRED;
                        next_ptr_reg            <= idx_next;
                        res_acq_reg             <= ptr_reg;
                        state_reg               <= S_EMIT;
                    end
                    else if (cnt_next == ring_n)
                    begin
                        res_status_reg <= dbrm_pkg::STAT_NONE_FREE;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_next;
                        ptr_reg <= idx_next;
                    end
                end

                // restoring divide, one quotient bit per cycle
                S_DIV:
                begin
                    rem_reg <= div_ge ? dbrm_pkg::SEQ_W'(div_trial - {1'b0, dvs_reg})
                                      : div_trial[dbrm_pkg::SEQ_W-1:0];
                    dq_reg  <= {dq_reg[dbrm_pkg::PERIOD_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output channel
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.acquired_slot = rsp_acq_reg;
    assign rsp.shown_slot    = rsp_shown_reg;
    assign rsp.presented     = rsp_presented_reg;
    assign rsp.period_ns     = rsp_period_reg;
    assign rsp.held_total    = rsp_held_reg;
    assign rsp.commit_total  = rsp_commit_reg;

    // a commit in flight and a held frame never coexist
    a_inflight_pending_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(inflight_valid_reg && pending_valid_reg))
        else $error("commit in flight while a frame is held");

    // the in-flight slot stays committed until its flip completes
    a_inflight_committed: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_valid_reg |-> (slot_state_reg[inflight_slot_reg] == dbrm_pkg::ST_COMMITTED))
        else $error("in-flight slot lost its committed state");

    // the free-slot search never runs past the ring
    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg < ring_n))
        else $error("slot search overran the ring");

    // a period is reported only with a credited flip
    a_period_only_on_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.presented) |-> (rsp.period_ns == '0))
        else $error("period reported without a credited flip");

endmodule
